// ===== hdl/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared sizes, codes and types of the character-cell text buffer.
// ----------------------------------------------------------------------------
package tcb_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 128;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int RLIM_W   = $clog2(MAX_ROWS + 1);
    localparam int CLIM_W   = $clog2(MAX_COLS + 1);
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CELL_W   = 16;

    localparam logic [7:0] DEFAULT_ATTR = 8'h07;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [6:0] ROWS_RESET   = 7'd25;
    localparam logic [7:0] COLS_RESET   = 8'd80;

    localparam logic [7:0] CFG_ACTIVE_ROWS = 8'd0;
    localparam logic [7:0] CFG_ACTIVE_COLS = 8'd1;

    typedef enum logic [1:0] {
        KIND_PUT    = 2'd0,
        KIND_GET    = 2'd1,
        KIND_SCROLL = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // effective active region, already clamped to the store
    typedef struct packed {
        logic [RLIM_W-1:0] rows;
        logic [CLIM_W-1:0] cols;
    } region_t;

    // walk position after one step of the shared counter unit
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } step_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              load;
        logic [CELL_W-1:0] value;
    } result_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(32'(r) * MAX_COLS + 32'(c));
    endfunction

endpackage

// ===== hdl/tcb_ram.sv =====
// ----------------------------------------------------------------------------
// tcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tcb_step.sv =====
// ----------------------------------------------------------------------------
// tcb_step
// Shared walk unit: advances a row/column position and flags the last cell.
// ----------------------------------------------------------------------------
module tcb_step (
    input  logic [tcb_pkg::ROW_W-1:0]  row,
    input  logic [tcb_pkg::COL_W-1:0]  col,
    input  logic [tcb_pkg::RLIM_W-1:0] row_lim,
    input  logic [tcb_pkg::CLIM_W-1:0] col_lim,
    output tcb_pkg::step_t             step
);
    import tcb_pkg::*;

    logic last_col;
    logic last_row;

    assign last_col = (CLIM_W'(col) + CLIM_W'(1)) == col_lim;
    assign last_row = (RLIM_W'(row) + RLIM_W'(1)) == row_lim;

    always_comb begin
        step.last = last_col && last_row;
        if (last_col) begin
            step.col = '0;
            step.row = row + ROW_W'(1);
        end else begin
            step.col = col + COL_W'(1);
            step.row = row;
        end
    end

endmodule

// ===== hdl/tcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcb_ctrl
// Sequencer: put, get through the registered RAM read, and store walks for the
// reset clear, scroll copy, scroll fill and region clear.
// ----------------------------------------------------------------------------
module tcb_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_kind,
    input  logic [7:0]                s_row,
    input  logic [7:0]                s_col,
    input  logic [7:0]                s_character,
    input  logic [7:0]                s_color,
    input  tcb_pkg::region_t          region,
    input  logic                      out_free,
    output tcb_pkg::ram_req_t         ram_req,
    input  logic [tcb_pkg::CELL_W-1:0] ram_rdata,
    output tcb_pkg::result_t          result
);
    import tcb_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_GET,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]        color_reg, color_next;
    logic              oor_reg, oor_next;

    logic [RLIM_W-1:0] row_lim;
    logic [CLIM_W-1:0] col_lim;
    step_t             step;
    logic              in_region;
    logic              empty;
    logic              accept;
    logic [ADDR_W-1:0] in_addr;
    logic [ROW_W-1:0]  last_row;

    tcb_step u_step (
        .row     (row_reg),
        .col     (col_reg),
        .row_lim (row_lim),
        .col_lim (col_lim),
        .step    (step)
    );

    assign in_region = (32'(s_row) < 32'(region.rows)) && (32'(s_col) < 32'(region.cols));
    assign empty     = (region.rows == '0) || (region.cols == '0);
    assign in_addr   = cell_addr(s_row[ROW_W-1:0], s_col[COL_W-1:0]);
    assign last_row  = ROW_W'(region.rows - RLIM_W'(1));
    assign s_ready   = (state_reg == ST_IDLE) && ((s_kind != KIND_GET) || out_free);
    assign accept    = s_valid && s_ready;

    always_comb begin
        unique case (state_reg)
            ST_INIT: begin
                row_lim = RLIM_W'(MAX_ROWS);
                col_lim = CLIM_W'(MAX_COLS);
            end
            ST_COPY: begin
                // copy walks destination rows 0 .. rows-2
                row_lim = region.rows - RLIM_W'(1);
                col_lim = region.cols;
            end
            default: begin
                row_lim = region.rows;
                col_lim = region.cols;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        color_next     = color_reg;
        oor_next       = oor_reg;
        ram_req        = '0;
        result.load    = 1'b0;
        result.value   = oor_reg ? {DEFAULT_ATTR, BLANK_CHAR} : ram_rdata;

        unique case (state_reg)
            ST_INIT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cell_addr(row_reg, col_reg);
                ram_req.wdata = '0;
                row_next      = step.row;
                col_next      = step.col;
                if (step.last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    row_next   = '0;
                    col_next   = '0;
                    color_next = s_color;
                    unique case (kind_t'(s_kind))
                        KIND_PUT: begin
                            ram_req.we    = in_region;
                            ram_req.waddr = in_addr;
                            ram_req.wdata = {s_color, s_character};
                        end
                        KIND_GET: begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = in_addr;
                            oor_next      = !in_region;
                            state_next    = ST_GET;
                        end
                        KIND_SCROLL: begin
                            // a single row goes straight to its fill at row 0
                            if (!empty) begin
                                if (region.rows == RLIM_W'(1)) begin
                                    state_next = ST_FILL;
                                end else begin
                                    state_next = ST_COPY;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            if (!empty) begin
                                state_next = ST_FILL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_GET: begin
                result.load = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_COPY: begin
                // read the row below now, write it one row up next cycle
                ram_req.re     = 1'b1;
                ram_req.raddr  = cell_addr(row_reg + ROW_W'(1), col_reg);
                pend_next      = 1'b1;
                pend_addr_next = cell_addr(row_reg, col_reg);
                row_next       = step.row;
                col_next       = step.col;
                if (step.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                row_next   = last_row;
                col_next   = '0;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cell_addr(row_reg, col_reg);
                ram_req.wdata = {color_reg, BLANK_CHAR};
                row_next      = step.row;
                col_next      = step.col;
                if (step.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // pending copy write; only live in copy and drain
        if (pend_reg) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = pend_addr_reg;
            ram_req.wdata = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            color_reg     <= '0;
            oor_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            color_reg     <= color_next;
            oor_reg       <= oor_next;
        end
    end

endmodule

// ===== hdl/text_cell_buffer_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// text_cell_buffer_scroll_unit
// Character-cell text buffer with put, get, scroll-up and clear.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  s_       | in        | s_valid / s_ready    | kind, row, col, character, color
//  m_       | out       | m_valid / m_ready    | cell_value
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Get reads through the registered RAM, then the result waits in the output
//  register while further items are taken. Scroll walks the copy, a drain
//  state and the last-row fill, or only the fill for a single row; clear walks
//  the fill; an empty region starts no walk. Walks go one cell per cycle through
//  the single RAM write port. After reset the whole store is swept to zero with
//  s_ready low; configuration writes are taken throughout (cfg_ready is always
//  high). A get is held off while the output register is full and not being
//  taken.
// ----------------------------------------------------------------------------
module text_cell_buffer_scroll_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_row,
    input  logic [7:0]  s_col,
    input  logic [7:0]  s_character,
    input  logic [7:0]  s_color,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_cell_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import tcb_pkg::*;

    logic [6:0]        active_rows_reg;
    logic [7:0]        active_cols_reg;
    logic              m_valid_reg;
    logic [CELL_W-1:0] m_cell_value_reg;
    region_t           region;
    ram_req_t          ram_req;
    logic [CELL_W-1:0] ram_rdata;
    result_t           result;
    logic              out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (32'(active_rows_reg) > MAX_ROWS) begin
            region.rows = RLIM_W'(MAX_ROWS);
        end else begin
            region.rows = RLIM_W'(active_rows_reg);
        end
        if (32'(active_cols_reg) > MAX_COLS) begin
            region.cols = CLIM_W'(MAX_COLS);
        end else begin
            region.cols = CLIM_W'(active_cols_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rows_reg <= ROWS_RESET;
            active_cols_reg <= COLS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_ACTIVE_ROWS) begin
                active_rows_reg <= cfg_data[6:0];
            end else if (cfg_index == CFG_ACTIVE_COLS) begin
                active_cols_reg <= cfg_data;
            end
        end
    end

    tcb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_character (s_character),
        .s_color     (s_color),
        .region      (region),
        .out_free    (out_free),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .result      (result)
    );

    tcb_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.load) begin
            m_cell_value_reg <= result.value;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_value = m_cell_value_reg;

    // a get keeps the input side closed for its read cycle
    a_get_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_GET) |=> !s_ready)
        else $error("input taken during get read cycle");

    // reset starts the store sweep, so no item is taken straight after it
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("item taken before store sweep");

    // a result only appears after an accepted get has passed the get state and loaded the output register
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_kind == KIND_GET, 2))
        else $error("result without a get");

    // the output register is never reloaded while its result is still held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !result.load)
        else $error("held result overwritten");

endmodule
